[src/motion_alarm_controller_top_macros.svh]
// ============================================================================
// motion_alarm_controller_top_macros.svh
// Assertion macros shared by the motion alarm controller RTL.
// ============================================================================
`ifndef MOTION_ALARM_CONTROLLER_TOP_MACROS_SVH
`define MOTION_ALARM_CONTROLLER_TOP_MACROS_SVH

// Clocked check, off while reset is high.
`define MAC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MAC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mac_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// mac_pkg
// Types, codes and constants of the motion alarm controller.
// ============================================================================
package mac_pkg;

   // word layouts
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;
   localparam int ACCEL_W    = 12;
   localparam int POT_W      = 10;
   localparam int THR_W      = 12;
   localparam int CODE_W     = 16;
   localparam int SECS_W     = 7;

   // command codes (req_tuser)
   typedef enum logic [1:0] {
      CMD_BUTTONS = 2'd0,
      CMD_MOTION  = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_POT     = 2'd3
   } cmd_type;

   // configuration register indexes
   localparam logic CSR_MOTION_THRESHOLD = 1'b0;
   localparam logic CSR_UNLOCK_CODE      = 1'b1;

   // alarm mode, one-hot internally
   typedef enum logic [3:0] {
      MODE_OFF     = 4'b0001,
      MODE_ARMED   = 4'b0010,
      MODE_PENDING = 4'b0100,
      MODE_ACTIVE  = 4'b1000
   } mode_type;

   // alarm_state codes on the result word
   localparam logic [1:0] ALARM_OFF     = 2'd0;
   localparam logic [1:0] ALARM_ARMED   = 2'd1;
   localparam logic [1:0] ALARM_PENDING = 2'd2;
   localparam logic [1:0] ALARM_ACTIVE  = 2'd3;

   localparam logic [SECS_W-1:0] MIN_SECS        = 7'd20;
   localparam logic [SECS_W-1:0] MAX_SECS        = 7'd120;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 12'd16;
   localparam logic [CODE_W-1:0] UNLOCK_RESET    = 16'h1234;
   localparam logic [3:0]        DIGIT_MAX       = 4'd9;

   // button sample, lock in bit 0
   typedef struct packed {
      logic centre;
      logic down;
      logic up;
      logic left;
      logic right;
      logic arm;
      logic lock;
   } btn_type;

   // controls into the motion detector
   typedef struct packed {
      logic sample_en;
      logic armed;
      logic clear;
   } motion_ctl_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         MODE_OFF:     c = ALARM_OFF;
         MODE_ARMED:   c = ALARM_ARMED;
         MODE_PENDING: c = ALARM_PENDING;
         MODE_ACTIVE:  c = ALARM_ACTIVE;
         default:      c = ALARM_OFF;
      endcase
      return c;
   endfunction

endpackage

[src/mac_code_entry.sv]
`timescale 1ns / 1ps
// ============================================================================
// mac_code_entry
// Cursor, BCD digit stepping and unlock code compare.
// ============================================================================
module mac_code_entry #(
   parameter int CODE_DIGITS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  mac_pkg::btn_type            btn,
   input  logic [mac_pkg::CODE_W-1:0]  unlock_code,
   output logic [1:0]                  cursor_next,
   output logic [mac_pkg::CODE_W-1:0]  entered_next,
   output logic                        match
);

   localparam int CURW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int EVW  = 4 * CODE_DIGITS;
   localparam int CMPW = (EVW > mac_pkg::CODE_W) ? EVW : mac_pkg::CODE_W;
   localparam logic [CURW-1:0] TOP = CURW'(CODE_DIGITS - 1);

   logic [CURW-1:0] cursor_ff, cursor_in, cursor_mv;
   logic [3:0]      digits_ff [CODE_DIGITS];
   logic [3:0]      digits_st [CODE_DIGITS];
   logic [3:0]      digits_in [CODE_DIGITS];
   logic [EVW-1:0]  ev_st, ev_cur;

   always_comb begin
      // cursor move, right wins over left
      cursor_mv = cursor_ff;
      if (btn.right) begin
         cursor_mv = (cursor_ff < TOP) ? cursor_ff + 1'b1 : TOP;
      end else if (btn.left) begin
         if (cursor_ff != '0) cursor_mv = cursor_ff - 1'b1;
      end

      for (int i = 0; i < CODE_DIGITS; i++) begin
         digits_st[i] = digits_ff[i];
         if (cursor_mv == CURW'(i)) begin
            if (btn.up) begin
               digits_st[i] = (digits_ff[i] >= mac_pkg::DIGIT_MAX) ? 4'd0
                                                                   : digits_ff[i] + 4'd1;
            end else if (btn.down) begin
               digits_st[i] = (digits_ff[i] == 4'd0 || digits_ff[i] > mac_pkg::DIGIT_MAX)
                              ? mac_pkg::DIGIT_MAX : digits_ff[i] - 4'd1;
            end
         end
      end

      // digit 0 is the most significant nibble
      for (int i = 0; i < CODE_DIGITS; i++) begin
         ev_st[4*(CODE_DIGITS-1-i) +: 4]  = digits_st[i];
         ev_cur[4*(CODE_DIGITS-1-i) +: 4] = digits_ff[i];
      end

      match = step_en && btn.centre && (CMPW'(ev_st) == CMPW'(unlock_code));

      cursor_in = step_en ? cursor_mv : cursor_ff;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (match)        digits_in[i] = 4'd0;
         else if (step_en) digits_in[i] = digits_st[i];
         else              digits_in[i] = digits_ff[i];
      end

      cursor_next  = 2'(cursor_in);
      entered_next = match ? '0 : (step_en ? mac_pkg::CODE_W'(ev_st)
                                           : mac_pkg::CODE_W'(ev_cur));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         for (int i = 0; i < CODE_DIGITS; i++) digits_ff[i] <= 4'd0;
      end else begin
         cursor_ff <= cursor_in;
         for (int i = 0; i < CODE_DIGITS; i++) digits_ff[i] <= digits_in[i];
      end
   end

endmodule

[src/mac_motion_detect.sv]
`timescale 1ns / 1ps
// ============================================================================
// mac_motion_detect
// Baseline capture and per-axis dead-zone window check.
// ============================================================================
module mac_motion_detect #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mac_pkg::motion_ctl_type      ctl,
   input  logic [mac_pkg::ACCEL_W-1:0]  accel_x,
   input  logic [mac_pkg::ACCEL_W-1:0]  accel_y,
   input  logic [mac_pkg::ACCEL_W-1:0]  accel_z,
   input  logic [mac_pkg::THR_W-1:0]    threshold,
   output logic                         hit
);

   localparam int CW = ((SAMPLE_BITS > mac_pkg::THR_W) ? SAMPLE_BITS : mac_pkg::THR_W) + 1;

   logic                   base_valid_ff, base_valid_in;
   logic [SAMPLE_BITS-1:0] base_ff [3];
   logic [SAMPLE_BITS-1:0] smp [3];
   logic [CW-1:0]          hi [3];
   logic [CW-1:0]          lo [3];
   logic                   capture;

   assign smp[0] = SAMPLE_BITS'(accel_x);
   assign smp[1] = SAMPLE_BITS'(accel_y);
   assign smp[2] = SAMPLE_BITS'(accel_z);

   always_comb begin
      capture = ctl.sample_en && !base_valid_ff && ctl.armed;
      hit     = 1'b0;
      for (int i = 0; i < 3; i++) begin
         hi[i] = CW'(base_ff[i]) + CW'(threshold);
         lo[i] = (CW'(base_ff[i]) > CW'(threshold)) ? CW'(base_ff[i]) - CW'(threshold) : '0;
         if (ctl.sample_en && base_valid_ff &&
             (CW'(smp[i]) > hi[i] || CW'(smp[i]) < lo[i])) hit = 1'b1;
      end
      if (ctl.clear)    base_valid_in = 1'b0;
      else if (capture) base_valid_in = 1'b1;
      else              base_valid_in = base_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) base_valid_ff <= 1'b0;
      else       base_valid_ff <= base_valid_in;
   end

   // baseline is only read while valid, so no reset
   always_ff @(posedge clock) begin
      if (capture) begin
         for (int i = 0; i < 3; i++) base_ff[i] <= smp[i];
      end
   end

endmodule

[src/motion_alarm_controller_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// motion_alarm_controller_top
// Motion alarm controller: lock/arm, code entry, motion check, countdown.
// ============================================================================
// One request word (button sample, accelerometer sample, one-second tick or
// potentiometer sample, chosen by req_tuser) is taken per clock and gives
// exactly one response word carrying the full controller status after that
// word. A word is captured in the request register. When it advances, it
// updates all state and lands in the response register, which drives
// rsp_tvalid. req_tready follows rsp_tready through the advance term of
// the request register. While rsp_tready stays high, a new word is taken
// every cycle. A stalled response holds the request register, and once that
// register is full too, req_tready drops. csr writes (motion_threshold,
// unlock_code) are expected only while no word is in flight. Reset is
// synchronous; there is no clearing pass.
// ============================================================================
`include "motion_alarm_controller_top_macros.svh"

module motion_alarm_controller_top #(
   parameter int SAMPLE_BITS = 12,
   parameter int CODE_DIGITS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // request words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // press_lock, press_arm, press_right, press_left, press_up, press_down,
   // press_centre, accel_x[11:0], accel_y[11:0], accel_z[11:0], pot_level[9:0]
   input  logic [mac_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[1:0]
   input  logic [1:0]                       req_tuser,
   // response words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // alarm_state[1:0], armed_flag, locked_flag, moving_flag, delay_seconds[6:0],
   // seconds_left[6:0], cursor_pos[1:0], entered_code[15:0], sounder_on
   output logic [mac_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration writes
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [mac_pkg::CODE_W-1:0]       csr_wdata
);

   // ---------------------------------------------------------------- csr
   logic [mac_pkg::THR_W-1:0]  threshold_ff;
   logic [mac_pkg::CODE_W-1:0] unlock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mac_pkg::THRESHOLD_RESET;
         unlock_ff    <= mac_pkg::UNLOCK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mac_pkg::CSR_MOTION_THRESHOLD: threshold_ff <= csr_wdata[mac_pkg::THR_W-1:0];
            mac_pkg::CSR_UNLOCK_CODE:      unlock_ff    <= csr_wdata;
            default:                       ;
         endcase
      end
   end

   // ---------------------------------------------------- request register
   logic                           s1_valid_ff, s1_valid_in;
   logic [mac_pkg::REQ_DATA_W-1:0] s1_data_ff;
   mac_pkg::cmd_type               s1_cmd_ff;
   logic                           req_fire, s1_adv;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mac_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // the word in the request register moves on when the response slot is free
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire)    s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      else             s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_tdata;
         s1_cmd_ff  <= mac_pkg::cmd_type'(req_tuser);
      end
   end

   // field unpack
   mac_pkg::btn_type            btn;
   logic [mac_pkg::ACCEL_W-1:0] ax, ay, az;
   logic [mac_pkg::POT_W-1:0]   pot;

   assign btn = mac_pkg::btn_type'(s1_data_ff[6:0]);
   assign ax  = s1_data_ff[18:7];
   assign ay  = s1_data_ff[30:19];
   assign az  = s1_data_ff[42:31];
   assign pot = s1_data_ff[52:43];

   // ---------------------------------------------------------------- state
   logic                         armed_ff, armed_in;
   logic                         locked_ff, locked_in;
   logic                         moving_ff, moving_in;
   mac_pkg::mode_type            mode_ff, mode_in;
   logic [mac_pkg::SECS_W-1:0]   interval_ff, interval_in;
   logic [mac_pkg::SECS_W-1:0]   remaining_ff, remaining_in;
   logic                         countdown_ff, countdown_in;

   logic                         do_btn, do_motion;
   logic                         match, hit;
   logic [1:0]                   cursor_next;
   logic [mac_pkg::CODE_W-1:0]   entered_next;
   mac_pkg::motion_ctl_type      mctl;
   logic [mac_pkg::SECS_W-1:0]   pot_secs;

   assign do_btn    = s1_adv && (s1_cmd_ff == mac_pkg::CMD_BUTTONS);
   assign do_motion = s1_adv && (s1_cmd_ff == mac_pkg::CMD_MOTION);

   assign mctl.sample_en = do_motion;
   assign mctl.armed     = armed_ff;
   assign mctl.clear     = match;

   mac_code_entry #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_code (
      .clock        (clock),
      .reset        (reset),
      .step_en      (do_btn),
      .btn          (btn),
      .unlock_code  (unlock_ff),
      .cursor_next  (cursor_next),
      .entered_next (entered_next),
      .match        (match)
   );

   mac_motion_detect #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_motion (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mctl),
      .accel_x   (ax),
      .accel_y   (ay),
      .accel_z   (az),
      .threshold (threshold_ff),
      .hit       (hit)
   );

   // pot reading / 8, clamped to the allowed interval
   always_comb begin
      pot_secs = pot[mac_pkg::POT_W-1:3];
      if (pot_secs <= mac_pkg::MIN_SECS)     pot_secs = mac_pkg::MIN_SECS;
      else if (pot_secs > mac_pkg::MAX_SECS) pot_secs = mac_pkg::MAX_SECS;
   end

   always_comb begin
      armed_in     = armed_ff;
      locked_in    = locked_ff;
      moving_in    = moving_ff;
      mode_in      = mode_ff;
      interval_in  = interval_ff;
      remaining_in = remaining_ff;
      countdown_in = countdown_ff;

      if (s1_adv) begin
         case (s1_cmd_ff)
            mac_pkg::CMD_BUTTONS: begin
               // lock toggles only when disarmed; arm sees the new lock
               if (!armed_ff && btn.lock) locked_in = !locked_ff;
               if (locked_in && btn.arm) begin
                  armed_in = 1'b1;
                  mode_in  = mac_pkg::MODE_ARMED;
               end
               if (match) begin
                  armed_in     = 1'b0;
                  locked_in    = 1'b0;
                  moving_in    = 1'b0;
                  mode_in      = mac_pkg::MODE_OFF;
                  interval_in  = mac_pkg::MIN_SECS;
                  remaining_in = '0;
                  countdown_in = 1'b0;
               end
            end
            mac_pkg::CMD_MOTION: begin
               if (hit) moving_in = 1'b1;
            end
            mac_pkg::CMD_TICK: begin
               if (armed_ff && moving_ff && !countdown_ff) begin
                  mode_in      = mac_pkg::MODE_PENDING;
                  remaining_in = interval_ff;
                  countdown_in = 1'b1;
               end else if (armed_ff && moving_ff) begin
                  if (remaining_ff != '0) remaining_in = remaining_ff - 1'b1;
                  if (remaining_in == '0) mode_in = mac_pkg::MODE_ACTIVE;
               end else begin
                  countdown_in = 1'b0;
                  remaining_in = '0;
               end
            end
            mac_pkg::CMD_POT: begin
               if (!armed_ff && mode_ff == mac_pkg::MODE_OFF) interval_in = pot_secs;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         locked_ff    <= 1'b0;
         moving_ff    <= 1'b0;
         mode_ff      <= mac_pkg::MODE_OFF;
         interval_ff  <= mac_pkg::MIN_SECS;
         remaining_ff <= '0;
         countdown_ff <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         locked_ff    <= locked_in;
         moving_ff    <= moving_in;
         mode_ff      <= mode_in;
         interval_ff  <= interval_in;
         remaining_ff <= remaining_in;
         countdown_ff <= countdown_in;
      end
   end

   // --------------------------------------------------- response register
   always_comb begin
      rsp_data_in = {2'b00,
                     armed_in && (mode_in == mac_pkg::MODE_ACTIVE),
                     entered_next,
                     cursor_next,
                     remaining_in,
                     interval_in,
                     moving_in,
                     locked_in,
                     armed_in,
                     mac_pkg::mode_code(mode_in)};
      if (s1_adv)                       rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      else                              rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ----------------------------------------------------------- assertions
   `MAC_ASSERT_NR(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid_ff,
                  "response valid right after reset")
   `MAC_ASSERT(a_armed_vs_mode, clock, reset,
               armed_ff == (mode_ff != mac_pkg::MODE_OFF), "armed flag and mode disagree")
   `MAC_ASSERT(a_countdown_cond, clock, reset, countdown_ff |-> (armed_ff && moving_ff),
               "countdown running while not armed and moving")
   `MAC_ASSERT(a_active_at_zero, clock, reset,
               (mode_ff == mac_pkg::MODE_ACTIVE) |-> (remaining_ff == '0),
               "alarm active with time left")
   `MAC_ASSERT(a_interval_range, clock, reset,
               (interval_ff >= mac_pkg::MIN_SECS) && (interval_ff <= mac_pkg::MAX_SECS),
               "interval out of range")

endmodule
